[rtl/core/uch_pkg.sv]
package uch_pkg;

    // Histogram geometry
    localparam int TABLE_DEPTH = 65536;   // 128 .. 1114112
    localparam int COUNT_WIDTH = 32;      // 8 .. 64
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CP_W        = 31;

    localparam logic [CP_W-1:0]   TABLE_LIMIT = CP_W'(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(TABLE_DEPTH - 1);

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    typedef enum logic [2:0] {
        ST_PARTIAL      = 3'd0,
        ST_COUNTED      = 3'd1,
        ST_OUT_OF_TABLE = 3'd2,
        ST_INVALID      = 3'd3,
        ST_READ         = 3'd4
    } status_t;

    // What the histogram stage has to do with an item
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t             op;
        status_t         status;
        logic [CP_W-1:0] code_point;
        addr_t           addr;
    } req_t;

    typedef struct packed {
        status_t         status;
        logic [CP_W-1:0] code_point;
        logic [31:0]     count;
    } res_t;

endpackage

[rtl/core/utf8_codepoint_histogram_core.sv]
// Channel | Handshake             | Payload
// --------+-----------------------+-----------------------------------
// input   | in_valid / in_stall   | kind, byte_value, query_point
// output  | out_valid / out_stall | status, code_point, count
//
// One item per cycle sustained while the output does not stall; an accepted
// item passes through the s1 register into the output register. Memory: one
// read and one write a cycle, with a forwarding register for a back-to-back
// hit on the same counter. After reset a clearing pass zeroes all TABLE_DEPTH
// entries (65536 as built), one a cycle; in_stall stays high meanwhile.
// A stalled output holds the histogram stage, which then stalls the input.
module utf8_codepoint_histogram_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  byte_value,
    input  logic [15:0] query_point,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [30:0] code_point,
    output logic [31:0] count
);

    uch_pkg::req_t   req;
    uch_pkg::res_t   res;
    logic            s1_valid;
    logic            busy;
    logic            accept;
    logic            out_free;
    logic            take;

    logic            out_valid_reg;
    uch_pkg::res_t   out_res_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign take     = s1_valid && out_free;
    assign in_stall = busy || (s1_valid && !out_free);
    assign accept   = in_valid && !in_stall;

    // decoder state advances on every accepted data byte
    uch_decoder u_decoder
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .kind        (kind),
        .byte_value  (byte_value),
        .query_point (query_point),
        .req         (req)
    );

    // read issued on accept; modify and write back when the item is taken
    uch_hist u_hist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .req      (req),
        .take     (take),
        .s1_valid (s1_valid),
        .busy     (busy),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign code_point = out_res_reg.code_point;
    assign count      = out_res_reg.count;

endmodule

[rtl/core/uch_decoder.sv]
module uch_decoder
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     kind,
    input  logic [7:0]               byte_value,
    input  logic [15:0]              query_point,
    output uch_pkg::req_t            req
);

    logic [2:0]              bl_reg;
    logic [2:0]              bl_next;
    logic [uch_pkg::CP_W-1:0] pv_reg;
    logic [uch_pkg::CP_W-1:0] pv_next;

    logic [2:0]               nl;
    logic [4:0]               sh;
    logic [uch_pkg::CP_W-1:0] cont_bits;
    logic [uch_pkg::CP_W-1:0] pv_sum;
    logic [uch_pkg::CP_W-1:0] qp;
    logic                     cp_done;
    logic [uch_pkg::CP_W-1:0] cp_val;

    always_comb
    begin
        nl        = bl_reg - 3'd1;
        sh        = 5'(nl) * 5'd6;
        cont_bits = uch_pkg::CP_W'(byte_value[5:0]) << sh;
        pv_sum    = pv_reg + cont_bits;
        qp        = uch_pkg::CP_W'(query_point);

        bl_next        = bl_reg;
        pv_next        = pv_reg;
        cp_done        = 1'b0;
        cp_val         = '0;
        req.op         = uch_pkg::OP_NONE;
        req.status     = uch_pkg::ST_PARTIAL;
        req.code_point = '0;
        req.addr       = '0;

        if (kind)
        begin
            req.status     = uch_pkg::ST_READ;
            req.code_point = qp;
            if (qp < uch_pkg::TABLE_LIMIT)
            begin
                req.op   = uch_pkg::OP_READ;
                req.addr = qp[uch_pkg::ADDR_W-1:0];
            end
        end
        else if (bl_reg != 3'd0)
        begin
            if (byte_value inside {[8'h80:8'hBF]})
            begin
                bl_next = nl;
                if (nl == 3'd0)
                begin
                    cp_done = 1'b1;
                    cp_val  = pv_sum;
                    pv_next = '0;
                end
                else
                begin
                    pv_next = pv_sum;
                end
            end
            else
            begin
                // bad continuation: lose the partial point and this byte
                bl_next    = 3'd0;
                pv_next    = '0;
                req.status = uch_pkg::ST_INVALID;
            end
        end
        else if (byte_value inside {[8'h00:8'h7F]})
        begin
            cp_done = 1'b1;
            cp_val  = uch_pkg::CP_W'(byte_value);
        end
        else if (byte_value inside {[8'hC0:8'hDF]})
        begin
            bl_next = 3'd1;
            pv_next = uch_pkg::CP_W'(byte_value[4:0]) << 6;
        end
        else if (byte_value inside {[8'hE0:8'hEF]})
        begin
            bl_next = 3'd2;
            pv_next = uch_pkg::CP_W'(byte_value[3:0]) << 12;
        end
        else if (byte_value inside {[8'hF0:8'hF7]})
        begin
            bl_next = 3'd3;
            pv_next = uch_pkg::CP_W'(byte_value[2:0]) << 18;
        end
        else if (byte_value inside {[8'hF8:8'hFB]})
        begin
            bl_next = 3'd4;
            pv_next = uch_pkg::CP_W'(byte_value[1:0]) << 24;
        end
        else if (byte_value inside {[8'hFC:8'hFD]})
        begin
            bl_next = 3'd5;
            pv_next = uch_pkg::CP_W'(byte_value[0]) << 30;
        end
        else
        begin
            // stray continuation, 0xFE or 0xFF
            req.status = uch_pkg::ST_INVALID;
        end

        if (cp_done)
        begin
            req.code_point = cp_val;
            if (cp_val < uch_pkg::TABLE_LIMIT)
            begin
                req.op     = uch_pkg::OP_COUNT;
                req.status = uch_pkg::ST_COUNTED;
                req.addr   = cp_val[uch_pkg::ADDR_W-1:0];
            end
            else
            begin
                req.status = uch_pkg::ST_OUT_OF_TABLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_reg <= 3'd0;
            pv_reg <= '0;
        end
        else if (step && !kind)
        begin
            bl_reg <= bl_next;
            pv_reg <= pv_next;
        end
    end

endmodule

[rtl/core/uch_hist.sv]
module uch_hist
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  uch_pkg::req_t req,
    input  logic          take,
    output logic          s1_valid,
    output logic          busy,
    output uch_pkg::res_t res
);

    uch_pkg::cnt_t  mem [uch_pkg::TABLE_DEPTH];
    uch_pkg::cnt_t  rdata_reg;

    logic           clr_reg;
    uch_pkg::addr_t clr_addr_reg;

    logic           s1_valid_reg;
    uch_pkg::req_t  s1_req_reg;

    logic           fwd_valid_reg;
    uch_pkg::addr_t fwd_addr_reg;
    uch_pkg::cnt_t  fwd_data_reg;

    uch_pkg::cnt_t  cur;
    uch_pkg::cnt_t  inc;
    logic [63:0]    cnt_wide;
    logic           rd_en;
    logic           we;
    uch_pkg::addr_t waddr;
    uch_pkg::cnt_t  wdata;

    assign s1_valid = s1_valid_reg;
    assign busy     = clr_reg;
    assign rd_en    = load && (req.op != uch_pkg::OP_NONE);

    always_comb
    begin
        // the last write may have landed on the edge that issued this read
        cur = (fwd_valid_reg && (fwd_addr_reg == s1_req_reg.addr)) ? fwd_data_reg : rdata_reg;
        inc = (&cur) ? cur : cur + uch_pkg::COUNT_WIDTH'(1);

        we    = clr_reg ||
                (s1_valid_reg && take && (s1_req_reg.op == uch_pkg::OP_COUNT));
        waddr = clr_reg ? clr_addr_reg : s1_req_reg.addr;
        wdata = clr_reg ? '0 : inc;

        case (s1_req_reg.op)
            uch_pkg::OP_COUNT: cnt_wide = 64'(inc);
            uch_pkg::OP_READ:  cnt_wide = 64'(cur);
            default:           cnt_wide = '0;
        endcase

        res.status     = s1_req_reg.status;
        res.code_point = s1_req_reg.code_point;
        res.count      = cnt_wide[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + uch_pkg::ADDR_W'(1);
                if (clr_addr_reg == uch_pkg::LAST_ADDR)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_req_reg <= req;
        end
        if (we)
        begin
            fwd_addr_reg <= waddr;
            fwd_data_reg <= wdata;
        end
    end

endmodule

[rtl/core/uch_checker.sv]
module uch_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        kind,
    input logic [7:0]  byte_value,
    input logic [15:0] query_point,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [30:0] code_point,
    input logic [31:0] count
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(code_point) && $stable(count))
        else $error("result item changed while stalled");

    // partial and invalid items carry no code point and no count
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == uch_pkg::ST_PARTIAL || status == uch_pkg::ST_INVALID)
            |-> code_point == '0 && count == '0)
        else $error("partial or invalid item with non-zero fields");

    // a counted point has a counter of at least one
    a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == uch_pkg::ST_COUNTED |-> count != '0)
        else $error("counted item with zero count");

    // a dropped out-of-table point reports no count
    a_out_of_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == uch_pkg::ST_OUT_OF_TABLE |-> count == '0)
        else $error("out-of-table item with a count");

endmodule

bind utf8_codepoint_histogram_core uch_checker u_uch_checker (.*);

[test/utf8_histogram_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, decodes the accepted bytes itself and compares
// each accepted result with the oldest one still awaited.
module utf8_histogram_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  byte_value,
    input  logic [15:0] query_point,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [30:0] code_point,
    input  logic [31:0] count,

    output int          fail_count,
    output int          outstanding
);

    uch_pkg::cnt_t            tally [uch_pkg::TABLE_DEPTH];
    logic [2:0]               cont_left;
    logic [uch_pkg::CP_W-1:0] gathered;
    uch_pkg::res_t            awaited [$];
    uch_pkg::res_t            want;
    int                       mismatches = 0;

    // Saturating increment of one counter; out of table points only report.
    function automatic uch_pkg::res_t bump_counter(input logic [uch_pkg::CP_W-1:0] cp);
        uch_pkg::res_t r;
        r.code_point = cp;
        if (cp < uch_pkg::TABLE_LIMIT)
        begin
            if (tally[cp[uch_pkg::ADDR_W-1:0]] != '1)
                tally[cp[uch_pkg::ADDR_W-1:0]] = tally[cp[uch_pkg::ADDR_W-1:0]] + 1'b1;
            r.status = uch_pkg::ST_COUNTED;
            r.count  = 32'(tally[cp[uch_pkg::ADDR_W-1:0]]);
        end
        else
        begin
            r.status = uch_pkg::ST_OUT_OF_TABLE;
            r.count  = '0;
        end
        return r;
    endfunction

    function automatic uch_pkg::res_t decode_item(input logic k, input logic [7:0] b,
                                                  input logic [15:0] q);
        uch_pkg::res_t r;
        int            n;
        r.status     = uch_pkg::ST_PARTIAL;
        r.code_point = '0;
        r.count      = '0;
        if (k)
        begin
            r.status     = uch_pkg::ST_READ;
            r.code_point = uch_pkg::CP_W'(q);
            if (uch_pkg::CP_W'(q) < uch_pkg::TABLE_LIMIT)
                r.count = 32'(tally[uch_pkg::ADDR_W'(q)]);
        end
        else if (cont_left != 3'd0)
        begin
            if (b[7:6] != 2'b10)
            begin
                // bad continuation: drop the partial point and the byte
                cont_left = 3'd0;
                gathered  = '0;
                r.status  = uch_pkg::ST_INVALID;
            end
            else
            begin
                cont_left = cont_left - 3'd1;
                gathered  = gathered + (uch_pkg::CP_W'(b[5:0]) << (6 * cont_left));
                if (cont_left == 3'd0)
                begin
                    r        = bump_counter(gathered);
                    gathered = '0;
                end
            end
        end
        else if (!b[7])
        begin
            r = bump_counter(uch_pkg::CP_W'(b));
        end
        else
        begin
            casez (b)
                8'b110?????: n = 1;
                8'b1110????: n = 2;
                8'b11110???: n = 3;
                8'b111110??: n = 4;
                8'b1111110?: n = 5;
                default:     n = 0;
            endcase
            if (n == 0)
            begin
                r.status = uch_pkg::ST_INVALID;
            end
            else
            begin
                gathered  = uch_pkg::CP_W'((32'h3F >> n) & b) << (6 * n);
                cont_left = 3'(n);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_left = 3'd0;
            gathered  = '0;
            awaited.delete();
            foreach (tally[i])
                tally[i] = '0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: result with none awaited: status %0d cp %h count %0d",
                             $time, status, code_point, count);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (code_point !== want.code_point)
                    begin
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, code_point);
                        mismatches++;
                    end
                    if (count !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, count);
                        mismatches++;
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                awaited.push_back(decode_item(kind, byte_value, query_point));
            outstanding <= awaited.size();
        end
        fail_count <= mismatches;
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the UTF-8 histogram core. All prediction and
// comparison lives in the checker instantiated beside the block.
module tb_top;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  byte_value;
    logic [15:0] query_point;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [30:0] code_point;
    logic [31:0] count;

    int          fail_count;
    int          outstanding;

    int          items_sent  = 0;
    bit          idle_on     = 1'b1;   // random gaps on both channels
    bit          drained_once = 1'b0;

    utf8_codepoint_histogram_core DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .byte_value  (byte_value),
        .query_point (query_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .code_point  (code_point),
        .count       (count)
    );

    utf8_histogram_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .byte_value  (byte_value),
        .query_point (query_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .code_point  (code_point),
        .count       (count),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure: out_stall is drawn high with a 19 percent chance while idling is on.
    always @(posedge clk)
    begin
        out_stall <= idle_on && ($urandom_range(99) < 19);
    end

    // Present one item and hold it until the block takes it. Any gap is
    // put in front of the item, so in_valid gets one assignment per edge.
    task automatic push_item(input logic k, input logic [7:0] b, input logic [15:0] q);
        if (idle_on)
        begin
            while ($urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        kind        <= k;
        byte_value  <= b;
        query_point <= q;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    // The unused field carries junk so that every bit of it toggles.
    task automatic send_byte(input logic [7:0] b);
        push_item(1'b0, b, 16'($urandom));
    endtask

    task automatic send_query(input logic [15:0] q);
        push_item(1'b1, 8'($urandom), q);
    endtask

    // One UTF-8 sequence of len bytes with random payload bits. A broken
    // one is cut short and followed by a byte that is no continuation.
    task automatic send_sequence(input int len, input bit broken);
        logic [7:0] lead;
        logic [7:0] bad;
        int         keep;
        case (len)
            1: lead = $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h66))
                                        : {1'b0, 7'($urandom)};
            // half the two-byte forms land in 0..255, some of them overlong, and they
            // pile up on counters that the reads also hit
            2: lead = $urandom_range(1) ? {6'b110000, 2'($urandom)}
                                        : {3'b110, 5'($urandom)};
            3: lead = {4'b1110, 4'($urandom)};
            4: lead = {5'b11110, 3'($urandom)};
            5: lead = {6'b111110, 2'($urandom)};
            default: lead = {7'b1111110, 1'($urandom)};
        endcase
        send_byte(lead);
        keep = broken ? $urandom_range(0, len - 2) : len - 1;
        repeat (keep)
            send_byte({2'b10, 6'($urandom)});
        if (broken)
        begin
            do
                bad = 8'($urandom);
            while (bad[7:6] == 2'b10);
            send_byte(bad);
        end
    endtask

    initial
    begin
        int pick;
        int len;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= 1'b0;
        byte_value  <= 8'h00;
        query_point <= 16'h0000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block clears its table first and holds in_stall
        // meanwhile; push_item simply waits that out.
        send_byte(8'h00);                       // smallest one-byte point
        send_byte(8'h7F);                       // largest one-byte point
        send_byte(8'h80);                       // stray continuation
        send_byte(8'hFE);                       // never a lead
        send_byte(8'hFF);
        send_byte(8'hC2); send_byte(8'hA9);     // two-byte form
        send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
        // four-byte point beyond the table
        send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
        // six-byte form, largest point there is
        send_byte(8'hFD);
        repeat (5) send_byte(8'hBF);
        send_byte(8'hC3); send_byte(8'h41);     // bad continuation, 'A' dropped
        send_byte(8'hC0); send_byte(8'h80);     // overlong zero, counts as 0
        send_query(16'h0000);
        send_query(16'h00A9);
        send_query(16'hFFFF);

        // Random part: mostly well-formed sequences, some reads, noise and
        // broken sequences.
        while (items_sent < 930)
        begin
            // a long stretch at full rate on both sides
            idle_on = !(items_sent >= 450 && items_sent < 600);

            // once, let everything drain before going on
            if (!drained_once && items_sent >= 300)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
                drained_once = 1'b1;
            end

            pick = $urandom_range(99);
            if (pick < 18)
            begin
                send_query($urandom_range(1) ? 16'($urandom_range(0, 255))
                                             : 16'($urandom));
            end
            else if (pick < 26)
            begin
                send_byte(8'($urandom));
            end
            else if (pick < 34)
            begin
                send_sequence($urandom_range(2, 6), 1'b1);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 35)      len = 1;
                else if (pick < 60) len = 2;
                else if (pick < 80) len = 3;
                else if (pick < 88) len = 4;
                else if (pick < 94) len = 5;
                else                len = 6;
                send_sequence(len, 1'b0);
            end
        end

        // Drain: stop input, let outstanding take in the last item and fall to zero,
        // then wait on to catch any stray result.
        idle_on = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("utf8_codepoint_histogram_core regression: pass");
        else
            $display("utf8_codepoint_histogram_core regression: fail");
        $finish;
    end

    // Fails the run if the clearing pass plus the whole stream do not finish in time.
    initial
    begin
        #2000000;
        $display("utf8_codepoint_histogram_core regression: fail");
        $finish;
    end

endmodule

[utf8_codepoint_histogram_core.f]
rtl/core/uch_pkg.sv
rtl/core/uch_decoder.sv
rtl/core/uch_hist.sv
rtl/core/utf8_codepoint_histogram_core.sv
rtl/core/uch_checker.sv
test/utf8_histogram_checker.sv
test/tb_top.sv
